FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent check macros shared by the complex ALU RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock, masked while reset is held
`define CAU_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex alu check failed");

// Check on the rising clock, live during reset as well
`define CAU_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("complex alu reset check failed");

`endif

FILE: rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and saturation helper for the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int KIND_BITS    = 4;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int SUM_BITS     = PROD_BITS + 2;
    localparam int DIV_STEPS    = WORD_BITS;
    localparam int SQ_REM_BITS  = WORD_BITS + 2;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_BITS-1:0]  SAT_MAX  = SUM_BITS'(WORD_MAX);
    localparam logic signed [SUM_BITS-1:0]  SAT_MIN  = SUM_BITS'(WORD_MIN);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_MUL  = 4'd2,
        KIND_DIV  = 4'd3,
        KIND_SDIV = 4'd4,
        KIND_CONJ = 4'd5,
        KIND_MOD  = 4'd6,
        KIND_EQ   = 4'd7,
        KIND_NE   = 4'd8
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] val;
        logic                        flag;
    } t_sat;

    // Per-item control and finished simple results
    typedef struct packed {
        logic                        valid;
        logic [KIND_BITS-1:0]        kind;
        logic                        neg_re;
        logic                        neg_im;
        logic                        ovf_re;
        logic                        ovf_im;
        logic signed [WORD_BITS-1:0] res_re;
        logic signed [WORD_BITS-1:0] res_im;
        logic                        cmp;
        logic                        flag;
        logic                        div0;
    } t_meta;

    // Everything one cell hands to the next
    typedef struct packed {
        t_meta                  meta;
        logic [PROD_BITS-1:0]   d;
        logic [PROD_BITS-1:0]   dr_re;
        logic [PROD_BITS-1:0]   dr_im;
        logic [WORD_BITS-1:0]   dn_re;
        logic [WORD_BITS-1:0]   dn_im;
        logic [WORD_BITS-1:0]   dq_re;
        logic [WORD_BITS-1:0]   dq_im;
        logic [SQ_REM_BITS-1:0] sr;
        logic [PROD_BITS-1:0]   sv;
        logic [WORD_BITS-1:0]   sq;
    } t_cell;

    // Clamp a wide signed value into the word range
    function automatic t_sat sat_word(input logic signed [SUM_BITS-1:0] v);
        t_sat s;
        if (v > SAT_MAX) begin
            s.val  = WORD_MAX;
            s.flag = 1'b1;
        end else if (v < SAT_MIN) begin
            s.val  = WORD_MIN;
            s.flag = 1'b1;
        end else begin
            s.val  = v[WORD_BITS-1:0];
            s.flag = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: rtl/cau_ifs.sv
// ----------------------------------------------------------------------------
// cau_ifs
// Request and response channels of the complex ALU.
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [cau_pkg::KIND_BITS-1:0]        kind;
    logic signed [cau_pkg::WORD_BITS-1:0] a_real;
    logic signed [cau_pkg::WORD_BITS-1:0] a_imag;
    logic signed [cau_pkg::WORD_BITS-1:0] b_real;
    logic signed [cau_pkg::WORD_BITS-1:0] b_imag;

    modport source (output valid, kind, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, kind, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cau_pkg::WORD_BITS-1:0] res_real;
    logic signed [cau_pkg::WORD_BITS-1:0] res_imag;
    logic                                 compare_true;
    logic [1:0]                           status;

    modport source (output valid, res_real, res_imag, compare_true, status, input ready);
    modport sink   (input valid, res_real, res_imag, compare_true, status, output ready);
endinterface

FILE: rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined Q16.16 complex ALU with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per valid/ready handshake: the operation kind
//   and two complex operands. o_rsp returns one response per request, in
//   order: real and imaginary result, compare flag and status.
//   Throughput is one request per cycle unless the output stalls. A request
//   passes from the accepting edge to o_rsp.valid through five front stages
//   (capture, multiply, sum, clamp, divider seed), 32 cells of the quotient
//   and root chain, which produce one quotient bit per lane and one root bit
//   each, and the output register. The chain length sets the latency.
//   Reset (i_rst_n low, synchronous) empties every stage and the output.
//   When the receiver holds o_rsp.ready low, one more response lands in the
//   skid entry behind the output register; after that i_req.ready drops and
//   the whole chain holds until the receiver takes the waiting response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_arithmetic_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_req,
    cau_out_if.source o_rsp
);

    cau_pkg::t_cell w_chain [0:cau_pkg::DIV_STEPS];
    logic           w_adv;
    logic           w_tail_v;
    logic           w_rsp_clear;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (i_req),
        .o_cell  (w_chain[0])
    );

    // Row of step cells
    genvar g;
    generate
        for (g = 0; g < cau_pkg::DIV_STEPS; g++) begin : g_cell
            cau_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_cell  (w_chain[g]),
                .o_cell  (w_chain[g+1])
            );
        end
    endgenerate

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (w_chain[cau_pkg::DIV_STEPS]),
        .o_adv   (w_adv),
        .o_rsp   (o_rsp)
    );

    // Checks
    assign w_tail_v    = w_chain[cau_pkg::DIV_STEPS].meta.valid;
    assign w_rsp_clear = (o_rsp.res_real == '0) && (o_rsp.res_imag == '0)
                      && !o_rsp.compare_true;

    `CAU_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_rsp.valid)
    `CAU_ASSERT(a_stall_has_out, !w_adv |-> o_rsp.valid)
    `CAU_ASSERT(a_tail_lands, w_tail_v && w_adv |=> o_rsp.valid)
    `CAU_ASSERT(a_div0_zero, o_rsp.valid && (o_rsp.status == cau_pkg::ST_DIV0) |-> w_rsp_clear)

endmodule

FILE: rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Input register, products, sums, saturation and divider set-up.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    cau_in_if.sink         i_req,
    output cau_pkg::t_cell o_cell
);

    localparam int W  = cau_pkg::WORD_BITS;
    localparam int P  = cau_pkg::PROD_BITS;
    localparam int S  = cau_pkg::SUM_BITS;
    localparam int F  = cau_pkg::FRAC_BITS;
    localparam int K  = cau_pkg::KIND_BITS;

    // Stage A: captured request
    logic                r_a_v;
    logic [K-1:0]        r_a_kind;
    logic signed [W-1:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;

    // Stage B: products
    logic                r_b_v;
    logic [K-1:0]        r_b_kind;
    logic signed [W-1:0] r_b_ar, r_b_ai, r_b_br, r_b_bi;
    logic signed [P-1:0] r_b_p0, r_b_p1, r_b_p2, r_b_p3, r_b_p4, r_b_p5;
    logic signed [P-1:0] n_b_p0, n_b_p1, n_b_p2, n_b_p3, n_b_p4, n_b_p5;
    logic signed [W-1:0] w_sq_x, w_sq_y;

    // Stage C: sums
    logic                r_c_v;
    logic [K-1:0]        r_c_kind;
    logic signed [S-1:0] r_c_re, r_c_im;
    logic [P-1:0]        r_c_d;
    logic                r_c_cmp;
    logic signed [S-1:0] n_c_re, n_c_im;
    logic [P-1:0]        n_c_d;
    logic                n_c_cmp;
    logic signed [W:0]   w_br_ext;
    logic [W:0]          w_br_abs;

    // Stage D: saturated results and magnitudes
    cau_pkg::t_meta      r_d_meta;
    logic [P-1:0]        r_d_mag_re, r_d_mag_im, r_d_d;
    cau_pkg::t_meta      n_d_meta;
    logic signed [S-1:0] w_scaled_re, w_scaled_im;
    cau_pkg::t_sat       w_sat_re, w_sat_im;
    logic [S-1:0]        w_abs_re, w_abs_im;
    logic                w_simple;

    // Stage E: divider and root entry
    cau_pkg::t_cell      r_e;
    cau_pkg::t_cell      n_e;
    logic [P-1:0]        w_top_re, w_top_im;

    assign i_req.ready = i_adv;

    // Capture request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_adv) begin
            r_a_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_kind <= i_req.kind;
            r_a_ar   <= i_req.a_real;
            r_a_ai   <= i_req.a_imag;
            r_a_br   <= i_req.b_real;
            r_a_bi   <= i_req.b_imag;
        end
    end

    // Multiply; the squaring pair serves both the divisor and the modulus
    assign w_sq_x = (r_a_kind == cau_pkg::KIND_MOD) ? r_a_ar : r_a_br;
    assign w_sq_y = (r_a_kind == cau_pkg::KIND_MOD) ? r_a_ai : r_a_bi;
    assign n_b_p0 = r_a_ar * r_a_br;
    assign n_b_p1 = r_a_ai * r_a_bi;
    assign n_b_p2 = r_a_ar * r_a_bi;
    assign n_b_p3 = r_a_ai * r_a_br;
    assign n_b_p4 = w_sq_x * w_sq_x;
    assign n_b_p5 = w_sq_y * w_sq_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_kind <= r_a_kind;
            r_b_ar   <= r_a_ar;
            r_b_ai   <= r_a_ai;
            r_b_br   <= r_a_br;
            r_b_bi   <= r_a_bi;
            r_b_p0   <= n_b_p0;
            r_b_p1   <= n_b_p1;
            r_b_p2   <= n_b_p2;
            r_b_p3   <= n_b_p3;
            r_b_p4   <= n_b_p4;
            r_b_p5   <= n_b_p5;
        end
    end

    // Form the sums per operation
    assign w_br_ext = (W+1)'(r_b_br);
    assign w_br_abs = w_br_ext[W] ? (W+1)'(-w_br_ext) : (W+1)'(w_br_ext);

    always_comb begin
        n_c_re  = '0;
        n_c_im  = '0;
        n_c_d   = $unsigned(r_b_p4) + $unsigned(r_b_p5);
        n_c_cmp = 1'b0;
        case (r_b_kind)
            cau_pkg::KIND_ADD: begin
                n_c_re = S'(r_b_ar) + S'(r_b_br);
                n_c_im = S'(r_b_ai) + S'(r_b_bi);
            end
            cau_pkg::KIND_SUB: begin
                n_c_re = S'(r_b_ar) - S'(r_b_br);
                n_c_im = S'(r_b_ai) - S'(r_b_bi);
            end
            cau_pkg::KIND_MUL: begin
                n_c_re = S'(r_b_p0) - S'(r_b_p1);
                n_c_im = S'(r_b_p2) + S'(r_b_p3);
            end
            cau_pkg::KIND_DIV: begin
                n_c_re = S'(r_b_p0) + S'(r_b_p1);
                n_c_im = S'(r_b_p3) - S'(r_b_p2);
            end
            cau_pkg::KIND_SDIV: begin
                // fold the divisor sign into the dividend
                n_c_re = w_br_ext[W] ? -S'(r_b_ar) : S'(r_b_ar);
                n_c_im = w_br_ext[W] ? -S'(r_b_ai) : S'(r_b_ai);
                n_c_d  = P'(w_br_abs);
            end
            cau_pkg::KIND_CONJ: begin
                n_c_re = S'(r_b_ar);
                n_c_im = -S'(r_b_ai);
            end
            cau_pkg::KIND_EQ: begin
                n_c_cmp = (r_b_ar == r_b_br) && (r_b_ai == r_b_bi);
            end
            cau_pkg::KIND_NE: begin
                n_c_cmp = (r_b_ar != r_b_br) || (r_b_ai != r_b_bi);
            end
            default: begin
                n_c_re = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_kind <= r_b_kind;
            r_c_re   <= n_c_re;
            r_c_im   <= n_c_im;
            r_c_d    <= n_c_d;
            r_c_cmp  <= n_c_cmp;
        end
    end

    // Scale products back to Q format, clamp, and take magnitudes for division
    assign w_scaled_re = (r_c_kind == cau_pkg::KIND_MUL) ? (r_c_re >>> F) : r_c_re;
    assign w_scaled_im = (r_c_kind == cau_pkg::KIND_MUL) ? (r_c_im >>> F) : r_c_im;
    assign w_sat_re    = cau_pkg::sat_word(w_scaled_re);
    assign w_sat_im    = cau_pkg::sat_word(w_scaled_im);
    assign w_abs_re    = r_c_re[S-1] ? S'(-r_c_re) : S'(r_c_re);
    assign w_abs_im    = r_c_im[S-1] ? S'(-r_c_im) : S'(r_c_im);
    assign w_simple    = (r_c_kind == cau_pkg::KIND_ADD) || (r_c_kind == cau_pkg::KIND_SUB)
                      || (r_c_kind == cau_pkg::KIND_MUL) || (r_c_kind == cau_pkg::KIND_CONJ);

    always_comb begin
        n_d_meta        = '0;
        n_d_meta.valid  = r_c_v;
        n_d_meta.kind   = r_c_kind;
        n_d_meta.neg_re = r_c_re[S-1];
        n_d_meta.neg_im = r_c_im[S-1];
        n_d_meta.cmp    = r_c_cmp;
        n_d_meta.div0   = ((r_c_kind == cau_pkg::KIND_DIV) || (r_c_kind == cau_pkg::KIND_SDIV))
                       && (r_c_d == '0);
        if (w_simple) begin
            n_d_meta.res_re = w_sat_re.val;
            n_d_meta.res_im = w_sat_im.val;
            n_d_meta.flag   = w_sat_re.flag | w_sat_im.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_meta.valid <= 1'b0;
        end else if (i_adv) begin
            r_d_meta <= n_d_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d_mag_re <= w_abs_re[P-1:0];
            r_d_mag_im <= w_abs_im[P-1:0];
            r_d_d      <= r_c_d;
        end
    end

    // Seed the cells: high part as first remainder, overflow if it already reaches d
    assign w_top_re = {{F{1'b0}}, r_d_mag_re[P-1:F]};
    assign w_top_im = {{F{1'b0}}, r_d_mag_im[P-1:F]};

    always_comb begin
        n_e             = '0;
        n_e.meta        = r_d_meta;
        n_e.meta.ovf_re = (w_top_re >= r_d_d);
        n_e.meta.ovf_im = (w_top_im >= r_d_d);
        n_e.d           = r_d_d;
        n_e.dr_re       = w_top_re;
        n_e.dr_im       = w_top_im;
        n_e.dn_re       = {r_d_mag_re[F-1:0], {(W-F){1'b0}}};
        n_e.dn_im       = {r_d_mag_im[F-1:0], {(W-F){1'b0}}};
        n_e.sv          = r_d_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.meta.valid <= 1'b0;
        end else if (i_adv) begin
            r_e <= n_e;
        end
    end

    assign o_cell = r_e;

endmodule

FILE: rtl/cau_cell.sv
// ----------------------------------------------------------------------------
// cau_cell
// One step of the quotient and root chain: a bit per divider lane, a root bit.
// ----------------------------------------------------------------------------
module cau_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cau_pkg::t_cell i_cell,
    output cau_pkg::t_cell o_cell
);

    localparam int W  = cau_pkg::WORD_BITS;
    localparam int P  = cau_pkg::PROD_BITS;
    localparam int R  = cau_pkg::SQ_REM_BITS;

    cau_pkg::t_cell r_cell;
    cau_pkg::t_cell n_cell;
    logic [P:0]     w_re_rem, w_re_diff, w_im_rem, w_im_diff;
    logic [R+1:0]   w_sq_rem, w_sq_trial, w_sq_diff;

    // Shift in the next dividend bit and subtract the divisor when it fits
    assign w_re_rem  = {i_cell.dr_re, i_cell.dn_re[W-1]};
    assign w_im_rem  = {i_cell.dr_im, i_cell.dn_im[W-1]};
    assign w_re_diff = w_re_rem - {1'b0, i_cell.d};
    assign w_im_diff = w_im_rem - {1'b0, i_cell.d};

    // Bring down two radicand bits and try the next root bit
    assign w_sq_rem   = {i_cell.sr, i_cell.sv[P-1:P-2]};
    assign w_sq_trial = {2'b00, i_cell.sq, 2'b01};
    assign w_sq_diff  = w_sq_rem - w_sq_trial;

    always_comb begin
        n_cell       = i_cell;
        n_cell.dr_re = w_re_diff[P] ? w_re_rem[P-1:0] : w_re_diff[P-1:0];
        n_cell.dr_im = w_im_diff[P] ? w_im_rem[P-1:0] : w_im_diff[P-1:0];
        n_cell.dq_re = {i_cell.dq_re[W-2:0], ~w_re_diff[P]};
        n_cell.dq_im = {i_cell.dq_im[W-2:0], ~w_im_diff[P]};
        n_cell.dn_re = {i_cell.dn_re[W-2:0], 1'b0};
        n_cell.dn_im = {i_cell.dn_im[W-2:0], 1'b0};
        n_cell.sr    = w_sq_diff[R+1] ? w_sq_rem[R-1:0] : w_sq_diff[R-1:0];
        n_cell.sq    = {i_cell.sq[W-2:0], ~w_sq_diff[R+1]};
        n_cell.sv    = {i_cell.sv[P-3:0], 2'b00};
    end

    // Advance to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.meta.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Sign and clamp the quotients and root, pick the result, output skid buffer.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cau_pkg::t_cell i_cell,
    output logic           o_adv,
    cau_out_if.source      o_rsp
);

    localparam int W = cau_pkg::WORD_BITS;

    typedef struct packed {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                cmp;
        logic [1:0]          status;
    } t_rsp;

    t_rsp          n_rsp;
    t_rsp          r_out, r_skid;
    logic          r_out_v, r_skid_v;
    logic          w_in_v;
    logic          w_flag;
    cau_pkg::t_sat w_fin_re, w_fin_im;

    // Apply sign to a quotient magnitude and clamp it
    function automatic cau_pkg::t_sat fin_div(input logic neg, input logic ovf,
                                              input logic [W-1:0] q);
        cau_pkg::t_sat s;
        s.flag = 1'b0;
        if (!neg) begin
            if (ovf || q[W-1]) begin
                s.val  = cau_pkg::WORD_MAX;
                s.flag = 1'b1;
            end else begin
                s.val = q;
            end
        end else begin
            if (ovf || (q > W'(cau_pkg::WORD_MIN))) begin
                s.val  = cau_pkg::WORD_MIN;
                s.flag = 1'b1;
            end else begin
                s.val = W'(0) - q;
            end
        end
        return s;
    endfunction

    assign w_fin_re = fin_div(i_cell.meta.neg_re, i_cell.meta.ovf_re, i_cell.dq_re);
    assign w_fin_im = fin_div(i_cell.meta.neg_im, i_cell.meta.ovf_im, i_cell.dq_im);

    // Select the finished fields per operation
    always_comb begin
        n_rsp.re  = i_cell.meta.res_re;
        n_rsp.im  = i_cell.meta.res_im;
        n_rsp.cmp = i_cell.meta.cmp;
        w_flag    = i_cell.meta.flag;
        case (i_cell.meta.kind)
            cau_pkg::KIND_DIV, cau_pkg::KIND_SDIV: begin
                if (i_cell.meta.div0) begin
                    n_rsp.re = '0;
                    n_rsp.im = '0;
                    w_flag   = 1'b0;
                end else begin
                    n_rsp.re = w_fin_re.val;
                    n_rsp.im = w_fin_im.val;
                    w_flag   = w_fin_re.flag | w_fin_im.flag;
                end
            end
            cau_pkg::KIND_MOD: begin
                n_rsp.re = i_cell.sq[W-1] ? cau_pkg::WORD_MAX : i_cell.sq;
                n_rsp.im = '0;
                w_flag   = i_cell.sq[W-1];
            end
            default: begin
                n_rsp.cmp = i_cell.meta.cmp;
            end
        endcase
        if (i_cell.meta.div0) begin
            n_rsp.status = cau_pkg::ST_DIV0;
        end else if (w_flag) begin
            n_rsp.status = cau_pkg::ST_SAT;
        end else begin
            n_rsp.status = cau_pkg::ST_OK;
        end
    end

    // Output register plus skid entry; the chain stalls only when both are full
    assign o_adv  = ~r_skid_v;
    assign w_in_v = i_cell.meta.valid & ~r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_rsp.ready) begin
            r_out_v  <= r_skid_v | w_in_v;
            r_skid_v <= 1'b0;
        end else if (w_in_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_rsp.ready) begin
            r_out <= r_skid_v ? r_skid : n_rsp;
        end else if (w_in_v) begin
            r_skid <= n_rsp;
        end
    end

    assign o_rsp.valid        = r_out_v;
    assign o_rsp.res_real     = r_out.re;
    assign o_rsp.res_imag     = r_out.im;
    assign o_rsp.compare_true = r_out.cmp;
    assign o_rsp.status       = r_out.status;

endmodule
